[src/call_stack_exclusive_time_assert.svh]
// call_stack_exclusive_time_assert.svh: assertion macros for the profiler checker
// no dependencies; included by the checker file
`ifndef CALL_STACK_EXCLUSIVE_TIME_ASSERT_SVH
`define CALL_STACK_EXCLUSIVE_TIME_ASSERT_SVH

// same-cycle implication, masked while in reset
`define CSET_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("cset assertion failed");

// next-cycle implication, masked while in reset
`define CSET_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("cset assertion failed");

// next-cycle implication that also holds through reset
`define CSET_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("cset assertion failed");

`endif

[src/cset_pkg.sv]
// cset_pkg: constants, codes and shared types of the exclusive-time profiler
// no dependencies; used by every other file of the block but the assertion header
package cset_pkg;

    // sizes
    localparam int NUM_FUNCS   = 64;
    localparam int STACK_DEPTH = 64;
    localparam int MODE_W      = 2;
    localparam int ID_W        = 6;
    localparam int TS_W        = 32;
    localparam int TOT_W       = 40;
    localparam int STATUS_W    = 2;
    localparam int STACK_AW    = $clog2(STACK_DEPTH);
    localparam int CNT_W       = STACK_AW + 1;
    localparam int TOT_AW      = $clog2(NUM_FUNCS);
    localparam int SLICE_W     = TS_W + 1;
    localparam int AMT_W       = SLICE_W + 1;

    localparam logic [CNT_W-1:0] STACK_FULL = CNT_W'(STACK_DEPTH);
    localparam logic [ID_W:0]    ID_LIMIT   = (ID_W + 1)'(NUM_FUNCS);
    localparam logic [TOT_W-1:0] TOTAL_MAX  = '1;

    // event modes
    typedef logic [MODE_W-1:0] t_mode;
    localparam t_mode MODE_START = 2'd0;
    localparam t_mode MODE_END   = 2'd1;
    localparam t_mode MODE_CLEAR = 2'd2;

    // result status codes
    typedef logic [STATUS_W-1:0] t_status;
    localparam t_status STATUS_OK    = 2'd0;
    localparam t_status STATUS_EMPTY = 2'd1;
    localparam t_status STATUS_FULL  = 2'd2;
    localparam t_status STATUS_BACK  = 2'd3;

    // request to the totals store
    typedef struct packed {
        logic              rd_en;
        logic [TOT_AW-1:0] rd_addr;
        logic              wr_en;
        logic [TOT_AW-1:0] wr_addr;
        logic [TOT_W-1:0]  wr_data;
        logic              clear;
    } t_tot_req;

endpackage

[src/cset_if.sv]
// cset_if: valid/ready channels for event words and result words
// depends on cset_pkg
interface cset_in_if;
    import cset_pkg::*;

    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [ID_W-1:0]   func_id;
    logic [TS_W-1:0]   timestamp;

    modport source (output valid, mode, func_id, timestamp, input ready);
    modport sink   (input valid, mode, func_id, timestamp, output ready);
endinterface

interface cset_out_if;
    import cset_pkg::*;

    logic                valid;
    logic                ready;
    logic                credited_valid;
    logic [ID_W-1:0]     credited_id;
    logic [TOT_W-1:0]    credited_total;
    logic [STATUS_W-1:0] status;

    modport source (output valid, credited_valid, credited_id, credited_total, status,
                    input ready);
    modport sink   (input valid, credited_valid, credited_id, credited_total, status,
                    output ready);
endinterface

[src/cset_totals.sv]
// cset_totals: per-function exclusive-time store, one registered read port
// depends on cset_pkg; valid bits make unwritten and cleared entries read as zero
module cset_totals (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  cset_pkg::t_tot_req        i_req,
    output logic [cset_pkg::TOT_W-1:0] o_rd_data
);
    import cset_pkg::*;

    logic [TOT_W-1:0]     r_mem [NUM_FUNCS];
    logic [NUM_FUNCS-1:0] r_vld;
    logic [TOT_W-1:0]     r_rd_data;
    logic                 r_rd_vld;

    // entry valid bits, all cleared at once by a clear request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_req.clear) begin
            r_vld <= '0;
        end else if (i_req.wr_en) begin
            r_vld[i_req.wr_addr] <= 1'b1;
        end
    end

    // storage array
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
            r_rd_vld  <= r_vld[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

[src/call_stack_exclusive_time.sv]
// Exclusive-time profiler. For every event word (start, end or clear) the accept cycle
// (S_IDLE) reads the total of the function on top of the call stack and the stack entry
// below it from their memories, and S_EXEC then adds the gap, writes the total and
// stack entry back and loads the result register. A new word is taken only once S_EXEC
// is done, so the block does not take a new event before it is through with the last,
// as the totals memory has a registered read. A clear takes the same path: totals carry
// per-entry valid bits, so no sweep over the table is needed. While a finished result
// is still unread the block keeps accepting and reading the next word, and holds its
// write-back until the result register frees up.
// depends on cset_pkg, cset_if, cset_totals
module call_stack_exclusive_time (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cset_in_if.sink   i_evt,
    cset_out_if.source o_res
);
    import cset_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state               r_state;
    logic [MODE_W-1:0]    r_mode;
    logic [ID_W-1:0]      r_fid;
    logic [TS_W-1:0]      r_ts;
    logic [CNT_W-1:0]     r_count;
    logic [SLICE_W-1:0]   r_slice;
    logic [ID_W-1:0]      r_top_id;
    logic [ID_W-1:0]      r_stack [STACK_DEPTH];
    logic [ID_W-1:0]      r_stk_rd;

    logic                 r_out_valid;
    logic                 r_out_cvalid;
    logic [ID_W-1:0]      r_out_id;
    logic [TOT_W-1:0]     r_out_total;
    logic [STATUS_W-1:0]  r_out_status;

    logic [CNT_W-1:0]     n_count;
    logic [SLICE_W-1:0]   n_slice;
    logic [ID_W-1:0]      n_top_id;

    logic                 accept;
    logic                 exec_go;
    logic [CNT_W-1:0]     below_top;
    logic [STACK_AW-1:0]  stk_rd_addr;
    logic                 is_end;
    logic                 empty;
    logic                 full;
    logic                 back;
    logic                 id_bad;
    logic [SLICE_W-1:0]   gap;
    logic [AMT_W-1:0]     amount;
    logic [TOT_W:0]       sum;
    logic [TOT_W-1:0]     new_total;
    logic [TOT_W-1:0]     tot_rd;
    logic                 do_push;
    logic                 do_pop;
    logic                 credit;
    logic                 do_clear;
    logic [STATUS_W-1:0]  status;
    t_tot_req             tot_req;

    // handshake
    assign i_evt.ready = (r_state == S_IDLE);
    assign accept      = i_evt.valid && i_evt.ready;
    assign exec_go     = (r_state == S_EXEC) && (!r_out_valid || o_res.ready);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE:  if (accept)  r_state <= S_EXEC;
                S_EXEC:  if (exec_go) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // capture the event word
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode <= i_evt.mode;
            r_fid  <= i_evt.func_id;
            r_ts   <= i_evt.timestamp;
        end
    end

    // stack memory: read the entry under the top, write on push
    assign below_top   = r_count - CNT_W'(2);
    assign stk_rd_addr = below_top[STACK_AW-1:0];

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_stk_rd <= r_stack[stk_rd_addr];
        end
        if (do_push) begin
            r_stack[r_count[STACK_AW-1:0]] <= r_fid;
        end
    end

    // decode and checks
    assign is_end   = (r_mode == MODE_END);
    assign empty    = (r_count == '0);
    assign full     = (r_count >= STACK_FULL);
    assign back     = ({1'b0, r_ts} < r_slice);
    assign id_bad   = ({1'b0, r_fid} >= ID_LIMIT);

    // credit arithmetic with saturation
    assign gap       = {1'b0, r_ts} - r_slice;
    assign amount    = {1'b0, gap} + AMT_W'(is_end);
    assign sum       = {1'b0, tot_rd} + (TOT_W + 1)'(amount);
    assign new_total = sum[TOT_W] ? TOTAL_MAX : sum[TOT_W-1:0];

    // outcome of the event
    always_comb begin
        do_push  = 1'b0;
        do_pop   = 1'b0;
        credit   = 1'b0;
        do_clear = 1'b0;
        status   = STATUS_OK;
        if (exec_go) begin
            case (r_mode)
                MODE_START: begin
                    if (id_bad) begin
                        status = STATUS_OK;
                    end else if (full) begin
                        status = STATUS_FULL;
                    end else if (back) begin
                        status = STATUS_BACK;
                    end else begin
                        do_push = 1'b1;
                        credit  = !empty;
                    end
                end
                MODE_END: begin
                    if (empty) begin
                        status = STATUS_EMPTY;
                    end else if (back) begin
                        status = STATUS_BACK;
                    end else begin
                        do_pop = 1'b1;
                        credit = 1'b1;
                    end
                end
                MODE_CLEAR: begin
                    do_clear = 1'b1;
                end
                default: begin
                    status = STATUS_OK;
                end
            endcase
        end
    end

    // next stack pointer, slice start and top id
    always_comb begin
        n_count  = r_count;
        n_slice  = r_slice;
        n_top_id = r_top_id;
        if (do_push) begin
            n_count  = r_count + CNT_W'(1);
            n_slice  = {1'b0, r_ts};
            n_top_id = r_fid;
        end else if (do_pop) begin
            n_count  = r_count - CNT_W'(1);
            n_slice  = {1'b0, r_ts} + SLICE_W'(1);
            n_top_id = r_stk_rd;
        end else if (do_clear) begin
            n_count = '0;
            n_slice = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_slice <= '0;
        end else begin
            r_count <= n_count;
            r_slice <= n_slice;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top_id <= n_top_id;
    end

    // totals store access
    always_comb begin
        tot_req.rd_en   = accept;
        tot_req.rd_addr = r_top_id[TOT_AW-1:0];
        tot_req.wr_en   = credit;
        tot_req.wr_addr = r_top_id[TOT_AW-1:0];
        tot_req.wr_data = new_total;
        tot_req.clear   = do_clear;
    end

    cset_totals u_totals (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (tot_req),
        .o_rd_data (tot_rd)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec_go) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_go) begin
            r_out_cvalid <= credit;
            r_out_id     <= credit ? r_top_id : '0;
            r_out_total  <= credit ? new_total : '0;
            r_out_status <= status;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.credited_valid = r_out_cvalid;
    assign o_res.credited_id    = r_out_id;
    assign o_res.credited_total = r_out_total;
    assign o_res.status         = r_out_status;

endmodule

[src/cset_checker.sv]
// cset_checker: port-level checks of the profiler, bound to the top level
// depends on cset_pkg and call_stack_exclusive_time_assert.svh
`include "call_stack_exclusive_time_assert.svh"

module cset_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic                         i_out_credited_valid,
    input logic [cset_pkg::ID_W-1:0]    i_out_credited_id,
    input logic [cset_pkg::TOT_W-1:0]   i_out_credited_total,
    input logic [cset_pkg::STATUS_W-1:0] i_out_status
);
    import cset_pkg::*;

    // a stalled result word holds
    `CSET_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_credited_total) && $stable(i_out_credited_id) && $stable(i_out_status))

    // one event in flight: no accept in the cycle after an accept
    `CSET_ASSERT_NEXT(a_one_inflight, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)

    // reset empties the result register
    `CSET_ASSERT_NEXT_ALWAYS(a_rst_empty, i_clk, !i_rst_n, !i_out_valid)

    // an error never credits a total
    `CSET_ASSERT_IMPLY(a_err_no_credit, i_clk, i_rst_n, i_out_valid && (i_out_status != STATUS_OK), !i_out_credited_valid)

    // no credit reports id and total zero
    `CSET_ASSERT_IMPLY(a_idle_fields, i_clk, i_rst_n, i_out_valid && !i_out_credited_valid, (i_out_credited_id == '0) && (i_out_credited_total == '0))

endmodule

bind call_stack_exclusive_time cset_checker u_cset_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .i_in_valid           (i_evt.valid),
    .i_in_ready           (i_evt.ready),
    .i_out_valid          (o_res.valid),
    .i_out_ready          (o_res.ready),
    .i_out_credited_valid (o_res.credited_valid),
    .i_out_credited_id    (o_res.credited_id),
    .i_out_credited_total (o_res.credited_total),
    .i_out_status         (o_res.status)
);

[tb/sv/call_stack_exclusive_time_test.sv]
// call_stack_exclusive_time_test: self-checking bench for the exclusive-time profiler
// a short table of event words is followed by random traces, checked against typed words or a local predictor
// depends on cset_pkg, cset_if and the call_stack_exclusive_time block
module call_stack_exclusive_time_test;
    import cset_pkg::*;

    localparam t_mode MODE_SPARE   = 2'd3;
    localparam int    RUN_LIMIT    = 5_000_000;
    localparam int    RANDOM_WORDS = 1000;
    localparam int    DRAIN_CYCLES = 20;

    typedef struct packed {
        logic              credited_valid;
        logic [ID_W-1:0]   credited_id;
        logic [TOT_W-1:0]  credited_total;
        t_status           status;
    } t_credit_word;

    typedef struct packed {
        t_mode             mode;
        logic [ID_W-1:0]   func_id;
        logic [TS_W-1:0]   timestamp;
        logic              typed;
        t_credit_word      word;
    } t_script_row;

    localparam t_credit_word W_OK    = '{1'b0, 6'd0, 40'd0, STATUS_OK};
    localparam t_credit_word W_EMPTY = '{1'b0, 6'd0, 40'd0, STATUS_EMPTY};
    localparam t_credit_word W_BACK  = '{1'b0, 6'd0, 40'd0, STATUS_BACK};

    // directed trace from reset; typed rows carry the word to expect, the rest use the predictor
    localparam t_script_row SCRIPT [24] = '{
        '{MODE_END,   6'd0,  32'h0000_0000, 1'b1, W_EMPTY},
        '{MODE_SPARE, 6'd63, 32'hFFFF_FFFF, 1'b1, W_OK},
        '{MODE_START, 6'd0,  32'h0000_0000, 1'b1, W_OK},
        '{MODE_START, 6'd63, 32'h0000_000A, 1'b1, '{1'b1, 6'd0, 40'd10, STATUS_OK}},
        '{MODE_START, 6'd5,  32'h0000_0005, 1'b1, W_BACK},
        '{MODE_END,   6'd0,  32'h0000_000A, 1'b0, W_OK},
        '{MODE_END,   6'd0,  32'h0000_0014, 1'b0, W_OK},
        '{MODE_END,   6'd0,  32'h0000_0019, 1'b1, W_EMPTY},
        '{MODE_START, 6'd42, 32'h0000_0014, 1'b1, W_BACK},
        '{MODE_START, 6'd42, 32'hFFFF_FFFF, 1'b1, W_OK},
        '{MODE_END,   6'd0,  32'hFFFF_FFFF, 1'b0, W_OK},
        '{MODE_START, 6'd1,  32'hFFFF_FFFF, 1'b1, W_BACK},
        '{MODE_END,   6'd0,  32'hFFFF_FFFF, 1'b1, W_EMPTY},
        '{MODE_START, 6'd2,  32'h0000_0000, 1'b1, W_BACK},
        '{MODE_CLEAR, 6'd21, 32'h5555_5555, 1'b1, W_OK},
        '{MODE_START, 6'd21, 32'h0000_0000, 1'b1, W_OK},
        '{MODE_START, 6'd42, 32'h0000_FFFF, 1'b0, W_OK},
        '{MODE_START, 6'd21, 32'hAAAA_AAAA, 1'b0, W_OK},
        '{MODE_END,   6'd0,  32'hAAAA_AAAA, 1'b0, W_OK},
        '{MODE_END,   6'd0,  32'hFFFF_FFFF, 1'b0, W_OK},
        '{MODE_END,   6'd0,  32'hFFFF_FFFF, 1'b0, W_OK},
        '{MODE_CLEAR, 6'd0,  32'h0000_0000, 1'b1, W_OK},
        '{MODE_END,   6'd0,  32'h0000_0000, 1'b1, W_EMPTY},
        '{MODE_START, 6'd63, 32'h0000_0000, 1'b1, W_OK}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    cset_in_if  evt_ch ();
    cset_out_if res_ch ();

    call_stack_exclusive_time u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_evt   (evt_ch),
        .o_res   (res_ch)
    );

    // profiler state as the bench sees it
    logic [ID_W-1:0]    prof_stack [STACK_DEPTH];
    logic [CNT_W-1:0]   prof_depth;
    logic [SLICE_W-1:0] prof_slice;
    logic [TOT_W-1:0]   prof_total [NUM_FUNCS];

    t_credit_word pending_credits [$];
    int           error_count = 0;
    bit           src_steady  = 1'b0;
    bit           sink_steady = 1'b0;

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // empty stack, zero totals, slice back at zero
    function automatic void clear_profile();
        for (int f = 0; f < NUM_FUNCS; f++) prof_total[f] = '0;
        prof_depth = '0;
        prof_slice = '0;
    endfunction

    // add time to the function on top of the stack, saturating
    function automatic t_credit_word credit_top(logic [AMT_W-1:0] amount);
        logic [ID_W-1:0]  id;
        logic [TOT_W:0]   sum;
        t_credit_word     w;
        id  = prof_stack[STACK_AW'(prof_depth - 1'b1)];
        sum = {1'b0, prof_total[id]} + (TOT_W + 1)'(amount);
        if (sum > {1'b0, TOTAL_MAX}) sum = {1'b0, TOTAL_MAX};
        prof_total[id] = sum[TOT_W-1:0];
        w = '{1'b1, id, sum[TOT_W-1:0], STATUS_OK};
        return w;
    endfunction

    // apply one event word and return the credit it causes
    function automatic t_credit_word apply_event(t_mode mode, logic [ID_W-1:0] fid,
                                                 logic [TS_W-1:0] ts);
        t_credit_word       w;
        logic [SLICE_W-1:0] at;
        w  = W_OK;
        at = {1'b0, ts};
        case (mode)
            MODE_START: begin
                if (int'(fid) >= NUM_FUNCS) begin
                    // ids past the table are dropped silently
                end else if (prof_depth >= STACK_FULL) begin
                    w.status = STATUS_FULL;
                end else if (at < prof_slice) begin
                    w.status = STATUS_BACK;
                end else begin
                    if (prof_depth != '0) w = credit_top(AMT_W'(at - prof_slice));
                    prof_stack[STACK_AW'(prof_depth)] = fid;
                    prof_depth = prof_depth + 1'b1;
                    prof_slice = at;
                end
            end
            MODE_END: begin
                if (prof_depth == '0) begin
                    w.status = STATUS_EMPTY;
                end else if (at < prof_slice) begin
                    w.status = STATUS_BACK;
                end else begin
                    w = credit_top(AMT_W'(at - prof_slice) + 1'b1);
                    prof_depth = prof_depth - 1'b1;
                    prof_slice = at + 1'b1;
                end
            end
            MODE_CLEAR: clear_profile();
            default: ;
        endcase
        return w;
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap(bit steady);
        int r;
        if (steady) return 0;
        r = $urandom_range(99, 0);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // timestamp at or after the running slice, mostly close, sometimes far
    function automatic logic [TS_W-1:0] next_timestamp();
        logic [SLICE_W:0] t;
        logic [TS_W-1:0]  delta;
        int               r;
        r = $urandom_range(99, 0);
        if (r < 70)      delta = $urandom_range(8, 0);
        else if (r < 95) delta = $urandom_range(5000, 0);
        else if (r < 99) delta = $urandom_range(32'h00FF_FFFF, 0);
        else             delta = $urandom();
        t = {1'b0, prof_slice} + delta;
        if (t > {2'b00, {TS_W{1'b1}}}) return '1;
        return t[TS_W-1:0];
    endfunction

    task automatic report_mismatch(string msg);
        error_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic compare_field(string name, logic [TOT_W-1:0] got, logic [TOT_W-1:0] want);
        if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    // offer one event word, wait for it to be taken, then queue its credit
    task automatic send_event(t_mode mode, logic [ID_W-1:0] fid, logic [TS_W-1:0] ts,
                              logic typed, t_credit_word typed_word);
        int           gap;
        t_credit_word predicted;
        gap = pick_gap(src_steady);
        if (gap > 0) begin
            evt_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        evt_ch.valid     <= 1'b1;
        evt_ch.mode      <= mode;
        evt_ch.func_id   <= fid;
        evt_ch.timestamp <= ts;
        @(posedge i_clk);
        while (!evt_ch.ready) @(posedge i_clk);
        predicted = apply_event(mode, fid, ts);
        pending_credits.push_back(typed ? typed_word : predicted);
    endtask

    // stimulus: reset, directed table, random traces, drain
    initial begin
        int    counted;
        int    seg_len;
        int    push_pct;
        int    r;
        bit    fill;
        t_mode mode;
        logic [TS_W-1:0] ts;

        i_rst_n          = 1'b0;
        evt_ch.valid     = 1'b0;
        evt_ch.mode      = MODE_START;
        evt_ch.func_id   = '0;
        evt_ch.timestamp = '0;
        clear_profile();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < $size(SCRIPT); k++) begin
            send_event(SCRIPT[k].mode, SCRIPT[k].func_id, SCRIPT[k].timestamp,
                       SCRIPT[k].typed, SCRIPT[k].word);
        end

        // random traces; a fill segment pushes past a full stack
        counted = 0;
        fill    = 1'b1;
        while (counted < RANDOM_WORDS) begin
            src_steady = ($urandom_range(4, 0) == 0);
            if (fill) begin
                seg_len  = STACK_DEPTH + $urandom_range(4, 1);
                push_pct = 100;
            end else begin
                seg_len  = $urandom_range(80, 20);
                push_pct = 30 + 15 * $urandom_range(4, 0);
            end
            if (fill || prof_slice > 33'h0_F000_0000 || $urandom_range(1, 0) == 1) begin
                send_event(MODE_CLEAR, ID_W'($urandom()), $urandom(), 1'b0, W_OK);
                counted++;
            end
            for (int i = 0; i < seg_len; i++) begin
                r = $urandom_range(99, 0);
                if (!fill && r < 3) begin
                    // spare mode is ignored by the block, so it does not count
                    send_event(MODE_SPARE, ID_W'($urandom()), $urandom(), 1'b0, W_OK);
                end else begin
                    if (!fill && r < 5) begin
                        mode = MODE_CLEAR;
                        ts   = $urandom();
                    end else if (!fill && r < 11 && prof_slice != '0) begin
                        // broken trace: time steps back
                        mode = ($urandom_range(1, 0) == 0) ? MODE_START : MODE_END;
                        ts   = $urandom_range(TS_W'(prof_slice - 1'b1), 0);
                    end else begin
                        mode = ($urandom_range(99, 0) < push_pct) ? MODE_START : MODE_END;
                        ts   = next_timestamp();
                    end
                    send_event(mode, ID_W'($urandom()), ts, 1'b0, W_OK);
                    counted++;
                end
            end
            fill = ($urandom_range(9, 0) == 0);
        end
        evt_ch.valid <= 1'b0;

        while (pending_credits.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_credits.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // result ready with random stalls, steady now and then
    initial begin
        int stall_left;
        int cycles;
        res_ch.ready = 1'b0;
        stall_left   = 0;
        cycles       = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles % 300 == 0) sink_steady = ($urandom_range(3, 0) == 0);
            if (stall_left > 0) begin
                res_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                res_ch.ready <= 1'b1;
                stall_left = pick_gap(sink_steady);
            end
        end
    end

    // compare each result word with the oldest pending credit
    always @(posedge i_clk) begin
        t_credit_word want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_credits.size() == 0) begin
                report_mismatch("result word with nothing pending");
            end else begin
                want = pending_credits.pop_front();
                compare_field("credited_valid", TOT_W'(res_ch.credited_valid),
                              TOT_W'(want.credited_valid));
                compare_field("credited_id", TOT_W'(res_ch.credited_id),
                              TOT_W'(want.credited_id));
                compare_field("credited_total", res_ch.credited_total, want.credited_total);
                compare_field("status", TOT_W'(res_ch.status), TOT_W'(want.status));
            end
        end
    end

    // run limit
    initial begin
        #RUN_LIMIT;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[call_stack_exclusive_time.f]
+incdir+src
src/cset_pkg.sv
src/cset_if.sv
src/cset_totals.sv
src/call_stack_exclusive_time.sv
src/cset_checker.sv
tb/sv/call_stack_exclusive_time_test.sv
